FILE: rtl/core/tms_pkg.sv
// package for the turing machine stepper: field widths, codes, transaction types
// and default sizes
// no dependencies
package tms_pkg;

    localparam int TAPE_CELLS_DEF       = 128;
    localparam int STATES_DEF           = 8;
    localparam int RULES_PER_STATE_DEF  = 8;
    localparam int ACTIONS_PER_RULE_DEF = 8;

    localparam logic [7:0] SPACE_SYM = 8'h20;

    localparam logic [2:0] OP_RULE_HDR = 3'd0;
    localparam logic [2:0] OP_RULE_ACT = 3'd1;
    localparam logic [2:0] OP_TAPE_WR  = 3'd2;
    localparam logic [2:0] OP_TAPE_RD  = 3'd3;
    localparam logic [2:0] OP_STEP     = 3'd4;
    localparam logic [2:0] OP_SET_HEAD = 3'd5;

    localparam logic [2:0] ACT_STOP  = 3'd0;
    localparam logic [2:0] ACT_PRINT = 3'd1;
    localparam logic [2:0] ACT_ERASE = 3'd2;
    localparam logic [2:0] ACT_RIGHT = 3'd3;
    localparam logic [2:0] ACT_LEFT  = 3'd4;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOMATCH = 2'd1;
    localparam logic [1:0] STAT_CLAMP   = 2'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] state_index;
        logic [2:0] branch_index;
        logic [2:0] slot_index;
        logic [2:0] action;
        logic [7:0] symbol;
        logic       match_any;
        logic [2:0] next_state;
        logic [6:0] cell_req;
    } tms_in_t;

    typedef struct packed {
        logic [7:0] read_symbol;
        logic [6:0] head_position;
        logic [2:0] current_state;
        logic [2:0] fired_branch;
        logic [1:0] status;
    } tms_out_t;

endpackage

FILE: rtl/core/tms_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module tms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/turing_machine_stepper.sv
// turing machine stepper top level: rule table, action table and tape in rams,
// sequenced by one control fsm; uses tms_pkg and tms_ram
//
// channel  | direction | handshake        | payload
// s_       | in        | s_valid/s_ready  | s_data  (tms_pkg::tms_in_t)
// m_       | out       | m_valid/m_ready  | m_data  (tms_pkg::tms_out_t)
//
// load, read and set transactions pass exec, then rdh for tape writes and head sets,
// then done; a step scans with one rule read per cycle from
// the rule ram, then one action per cycle from the action ram, tape ram around it
// after reset a clear sweep over every address of the largest ram initializes
// all rams while s_ready stays low
// a new transaction is taken while the previous result still waits in m_data
module turing_machine_stepper #(
    parameter int TAPE_CELLS       = tms_pkg::TAPE_CELLS_DEF,
    parameter int STATES           = tms_pkg::STATES_DEF,
    parameter int RULES_PER_STATE  = tms_pkg::RULES_PER_STATE_DEF,
    parameter int ACTIONS_PER_RULE = tms_pkg::ACTIONS_PER_RULE_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tms_pkg::tms_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tms_pkg::tms_out_t  m_data
);

    import tms_pkg::*;

    localparam int TW     = $clog2(TAPE_CELLS);
    localparam int SW     = $clog2(STATES);
    localparam int BW     = (RULES_PER_STATE > 1) ? $clog2(RULES_PER_STATE) : 1;
    localparam int AIW    = (ACTIONS_PER_RULE > 1) ? $clog2(ACTIONS_PER_RULE) : 1;
    localparam int NRULES = STATES * RULES_PER_STATE;
    localparam int NACTS  = NRULES * ACTIONS_PER_RULE;
    localparam int NRW    = (NRULES > 1) ? $clog2(NRULES) : 1;
    localparam int NAW    = (NACTS > 1) ? $clog2(NACTS) : 1;
    localparam int CD0    = (TAPE_CELLS > NRULES) ? TAPE_CELLS : NRULES;
    localparam int CD     = (CD0 > NACTS) ? CD0 : NACTS;
    localparam int CLW    = $clog2(CD);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_EXEC  = 4'd2;
    localparam logic [3:0] ST_UNDER = 4'd3;
    localparam logic [3:0] ST_SCAN  = 4'd4;
    localparam logic [3:0] ST_ACT   = 4'd5;
    localparam logic [3:0] ST_RDH   = 4'd6;
    localparam logic [3:0] ST_DONE  = 4'd7;

    logic [3:0]     state_reg, state_next;
    tms_in_t        in_reg, in_next;
    logic [TW-1:0]  head_reg, head_next;
    logic [SW-1:0]  ms_reg, ms_next;
    logic [7:0]     under_reg, under_next;
    logic [BW-1:0]  scan_b_reg, scan_b_next;
    logic [AIW-1:0] act_a_reg, act_a_next;
    logic [NRW-1:0] act_base_reg, act_base_next;
    logic [2:0]     fired_reg, fired_next;
    logic [1:0]     status_reg, status_next;
    logic           oob_reg, oob_next;
    logic [CLW-1:0] clr_reg, clr_next;
    logic           m_valid_reg, m_valid_next;
    tms_out_t       out_reg, out_next;

    logic           tape_we, tape_re;
    logic [TW-1:0]  tape_waddr, tape_raddr;
    logic [7:0]     tape_wdata, tape_rdata;
    logic           rule_we, rule_re;
    logic [NRW-1:0] rule_waddr, rule_raddr;
    logic [11:0]    rule_wdata, rule_rdata;
    logic           act_we, act_re;
    logic [NAW-1:0] act_waddr, act_raddr;
    logic [10:0]    act_wdata, act_rdata;

    logic           cell_ok, rule_wr_ok, act_wr_ok, rule_hit;
    logic [TW-1:0]  cell_idx;
    logic [NRW-1:0] cur_rule_addr, ld_rule_addr;
    logic [SW-1:0]  fire_state, set_state;
    logic [2:0]     a_kind;

    tms_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape (
        .aclk(aclk), .we(tape_we), .waddr(tape_waddr), .wdata(tape_wdata),
        .re(tape_re), .raddr(tape_raddr), .rdata(tape_rdata)
    );

    tms_ram #(.WIDTH(12), .DEPTH(NRULES)) u_rule (
        .aclk(aclk), .we(rule_we), .waddr(rule_waddr), .wdata(rule_wdata),
        .re(rule_re), .raddr(rule_raddr), .rdata(rule_rdata)
    );

    tms_ram #(.WIDTH(11), .DEPTH(NACTS)) u_act (
        .aclk(aclk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
        .re(act_re), .raddr(act_raddr), .rdata(act_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign cell_ok    = 32'(in_reg.cell_req) < TAPE_CELLS;
    assign cell_idx   = TW'(in_reg.cell_req);
    assign rule_wr_ok = (32'(in_reg.state_index) < STATES)
                        && (32'(in_reg.branch_index) < RULES_PER_STATE);
    assign act_wr_ok  = rule_wr_ok && (32'(in_reg.slot_index) < ACTIONS_PER_RULE);
    assign ld_rule_addr  = NRW'(32'(in_reg.state_index) * RULES_PER_STATE
                                + 32'(in_reg.branch_index));
    assign cur_rule_addr = NRW'(32'(ms_reg) * RULES_PER_STATE + 32'(scan_b_reg));
    assign rule_hit   = rule_rdata[11] || (rule_rdata[7:0] == under_reg);
    assign fire_state = (32'(rule_rdata[10:8]) >= STATES) ? SW'(STATES - 1)
                                                          : SW'(rule_rdata[10:8]);
    assign set_state  = (32'(in_reg.state_index) >= STATES) ? SW'(STATES - 1)
                                                            : SW'(in_reg.state_index);
    assign a_kind     = act_rdata[10:8];

    always_comb begin
        state_next    = state_reg;
        in_next       = in_reg;
        head_next     = head_reg;
        ms_next       = ms_reg;
        under_next    = under_reg;
        scan_b_next   = scan_b_reg;
        act_a_next    = act_a_reg;
        act_base_next = act_base_reg;
        fired_next    = fired_reg;
        status_next   = status_reg;
        oob_next      = oob_reg;
        clr_next      = clr_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        tape_we    = 1'b0;
        tape_waddr = head_reg;
        tape_wdata = 8'h00;
        tape_re    = 1'b0;
        tape_raddr = head_reg;
        rule_we    = 1'b0;
        rule_waddr = ld_rule_addr;
        rule_wdata = {in_reg.match_any, in_reg.next_state, in_reg.symbol};
        rule_re    = 1'b0;
        rule_raddr = cur_rule_addr;
        act_we     = 1'b0;
        act_waddr  = NAW'(32'(ld_rule_addr) * ACTIONS_PER_RULE + 32'(in_reg.slot_index));
        act_wdata  = {in_reg.action, in_reg.symbol};
        act_re     = 1'b0;
        act_raddr  = NAW'(32'(act_base_reg) * ACTIONS_PER_RULE + 32'(act_a_reg) + 1);

        unique case (state_reg)
            ST_CLEAR: begin
                tape_we    = 32'(clr_reg) < TAPE_CELLS;
                tape_waddr = TW'(clr_reg);
                tape_wdata = SPACE_SYM;
                rule_we    = 32'(clr_reg) < NRULES;
                rule_waddr = NRW'(clr_reg);
                rule_wdata = '0;
                act_we     = 32'(clr_reg) < NACTS;
                act_waddr  = NAW'(clr_reg);
                act_wdata  = '0;
                if (32'(clr_reg) == CD - 1) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    in_next     = s_data;
                    status_next = STAT_OK;
                    fired_next  = 3'd0;
                    oob_next    = 1'b0;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (in_reg.op)
                    OP_RULE_HDR: begin
                        rule_we    = rule_wr_ok;
                        tape_re    = 1'b1;
                        state_next = ST_DONE;
                    end
                    OP_RULE_ACT: begin
                        act_we     = act_wr_ok;
                        tape_re    = 1'b1;
                        state_next = ST_DONE;
                    end
                    OP_TAPE_WR: begin
                        tape_we    = cell_ok;
                        tape_waddr = cell_idx;
                        tape_wdata = in_reg.symbol;
                        state_next = ST_RDH;
                    end
                    OP_TAPE_RD: begin
                        tape_re    = 1'b1;
                        tape_raddr = cell_idx;
                        oob_next   = !cell_ok;
                        state_next = ST_DONE;
                    end
                    OP_STEP: begin
                        tape_re    = 1'b1;
                        state_next = ST_UNDER;
                    end
                    OP_SET_HEAD: begin
                        head_next  = cell_ok ? cell_idx : TW'(TAPE_CELLS - 1);
                        ms_next    = set_state;
                        if (!cell_ok) begin
                            status_next = STAT_CLAMP;
                        end
                        state_next = ST_RDH;
                    end
                    default: begin
                        tape_re    = 1'b1;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_UNDER: begin
                under_next  = tape_rdata;
                scan_b_next = '0;
                rule_re     = 1'b1;
                rule_raddr  = NRW'(32'(ms_reg) * RULES_PER_STATE);
                state_next  = ST_SCAN;
            end
            ST_SCAN: begin
                if (rule_hit) begin
                    ms_next       = fire_state;
                    fired_next    = 3'(scan_b_reg);
                    act_base_next = cur_rule_addr;
                    act_a_next    = '0;
                    act_re        = 1'b1;
                    act_raddr     = NAW'(32'(cur_rule_addr) * ACTIONS_PER_RULE);
                    state_next    = ST_ACT;
                end else if (32'(scan_b_reg) == RULES_PER_STATE - 1) begin
                    status_next = STAT_NOMATCH;
                    tape_re     = 1'b1;
                    state_next  = ST_DONE;
                end else begin
                    scan_b_next = BW'(32'(scan_b_reg) + 1);
                    rule_re     = 1'b1;
                    rule_raddr  = NRW'(32'(ms_reg) * RULES_PER_STATE
                                       + 32'(scan_b_reg) + 1);
                end
            end
            ST_ACT: begin
                unique case (a_kind)
                    ACT_PRINT: begin
                        tape_we    = 1'b1;
                        tape_wdata = act_rdata[7:0];
                    end
                    ACT_ERASE: begin
                        tape_we    = 1'b1;
                        tape_wdata = 8'h00;
                    end
                    ACT_RIGHT: begin
                        if (32'(head_reg) + 1 < TAPE_CELLS) begin
                            head_next = head_reg + 1'b1;
                        end else begin
                            status_next = STAT_CLAMP;
                        end
                    end
                    ACT_LEFT: begin
                        if (head_reg != '0) begin
                            head_next = head_reg - 1'b1;
                        end else begin
                            status_next = STAT_CLAMP;
                        end
                    end
                    default: begin
                    end
                endcase
                if (a_kind == ACT_STOP || a_kind > ACT_LEFT
                    || 32'(act_a_reg) == ACTIONS_PER_RULE - 1) begin
                    state_next = ST_RDH;
                end else begin
                    act_a_next = AIW'(32'(act_a_reg) + 1);
                    act_re     = 1'b1;
                end
            end
            ST_RDH: begin
                tape_re    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.read_symbol   = oob_reg ? 8'h00 : tape_rdata;
                    out_next.head_position = 7'(head_reg);
                    out_next.current_state = 3'(ms_reg);
                    out_next.fired_branch  = fired_reg;
                    out_next.status        = status_reg;
                    m_valid_next           = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            head_reg    <= '0;
            ms_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            head_reg    <= head_next;
            ms_reg      <= ms_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg       <= in_next;
        under_reg    <= under_next;
        scan_b_reg   <= scan_b_next;
        act_a_reg    <= act_a_next;
        act_base_reg <= act_base_next;
        fired_reg    <= fired_next;
        status_reg   <= status_next;
        oob_reg      <= oob_next;
        out_reg      <= out_next;
    end

    a_no_tape_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(tape_we && tape_re))
        else $error("tape ram written and read in the same cycle");

    a_head_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(head_reg) < TAPE_CELLS)
        else $error("head outside the tape");

    a_state_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(ms_reg) < STATES)
        else $error("machine state outside the state count");

    a_nomatch_branch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.status == STAT_NOMATCH |-> out_reg.fired_branch == 3'd0)
        else $error("fired branch set on an unmatched step");

    a_ready_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_EXEC)
        else $error("accepted transaction did not start execution");

endmodule
